// ===== design/rtc_pkg.sv =====
// Shared constants, command/status types and calendar tables for the RTC calendar tracker.
package rtc_pkg;

  localparam int CntW   = 32;
  localparam int YearW  = 8;
  localparam int MonW   = 4;
  localparam int DayW   = 5;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int ShiftW = 3;

  localparam logic [CntW-1:0] SecMin      = 32'd60;
  localparam logic [CntW-1:0] SecHour     = 32'd3600;
  localparam logic [CntW-1:0] SecDay      = 32'd86400;
  localparam logic [CntW-1:0] SecYear     = SecDay * 32'd365;
  localparam logic [CntW-1:0] SecLeap     = SecDay * 32'd366;
  localparam logic [CntW-1:0] SecBlock    = 32'd4 * SecYear + SecDay;
  localparam logic [CntW-1:0] MaxStepJump = 32'd180;

  localparam logic [MonW-1:0]  LastMonth = 4'd11;
  localparam logic [MonW-1:0]  NumMonths = 4'd12;
  localparam logic [HourW-1:0] LastHour  = 5'd23;
  localparam logic [MinW-1:0]  LastMin   = 6'd59;

  // datapath operations
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_LATCH     = 3'd1;
  localparam logic [2:0] OP_CONV_INIT = 3'd2;
  localparam logic [2:0] OP_INC_INIT  = 3'd3;
  localparam logic [2:0] OP_STEP      = 3'd4;
  localparam logic [2:0] OP_SEC       = 3'd5;
  localparam logic [2:0] OP_PUBLISH   = 3'd6;

  // compare/subtract step selectors
  localparam logic [2:0] SEL_BLK  = 3'd0;
  localparam logic [2:0] SEL_DAY  = 3'd1;
  localparam logic [2:0] SEL_HOUR = 3'd2;
  localparam logic [2:0] SEL_MIN  = 3'd3;
  localparam logic [2:0] SEL_LEAP = 3'd4;
  localparam logic [2:0] SEL_YEAR = 3'd5;
  localparam logic [2:0] SEL_MON  = 3'd6;
  localparam logic [2:0] SEL_INC  = 3'd7;

  typedef struct packed {
    logic [2:0]        op;
    logic [2:0]        sel;
    logic [ShiftW-1:0] shift;
  } dp_cmd_t;

  typedef struct packed {
    logic is_load;
    logic same;
    logic big;
    logic take;
  } dp_stat_t;

  function automatic logic [DayW-1:0] month_days(input logic leap, input logic [MonW-1:0] mon);
    logic [DayW-1:0] d;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                    d = 5'd30;
      4'd1:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd30;
    endcase
    return d;
  endfunction

  // subtrahend for one compare/subtract step
  function automatic logic [CntW-1:0] step_cand(input logic [2:0] sel,
                                                input logic [ShiftW-1:0] shift,
                                                input logic leap,
                                                input logic [MonW-1:0] mon);
    logic [CntW-1:0] c;
    case (sel)
      SEL_BLK:  c = SecBlock << shift;
      SEL_DAY:  c = SecDay << shift;
      SEL_HOUR: c = SecHour << shift;
      SEL_MIN:  c = SecMin << shift;
      SEL_LEAP: c = SecLeap;
      SEL_YEAR: c = SecYear;
      SEL_MON:  c = CntW'(month_days(leap, mon)) * SecDay;
      default:  c = SecMin;
    endcase
    return c;
  endfunction

endpackage

// ===== design/rtc_in_if.sv =====
// Input channel: counter reading and command with valid/ready.
interface rtc_in_if;
  import rtc_pkg::*;
  logic            valid;
  logic            ready;
  logic            cmd;
  logic [CntW-1:0] counter_value;
  modport source(output valid, output cmd, output counter_value, input ready);
  modport sink(input valid, input cmd, input counter_value, output ready);
endinterface

// ===== design/rtc_out_if.sv =====
// Output channel: calendar fields and total seconds with valid/ready.
interface rtc_out_if;
  import rtc_pkg::*;
  logic             valid;
  logic             ready;
  logic [YearW-1:0] year;
  logic [MonW-1:0]  month;
  logic [DayW-1:0]  day;
  logic [HourW-1:0] hour;
  logic [MinW-1:0]  minute;
  logic [SecW-1:0]  second;
  logic [CntW-1:0]  total_seconds;
  modport source(output valid, output year, output month, output day, output hour,
                 output minute, output second, output total_seconds, input ready);
  modport sink(input valid, input year, input month, input day, input hour,
               input minute, input second, input total_seconds, output ready);
endinterface

// ===== design/rtc_dp.sv =====
// Datapath: calendar state, remainder register, shared compare/subtract unit, output register.
module rtc_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  rtc_pkg::dp_cmd_t             cmd,
  output rtc_pkg::dp_stat_t            stat,
  input  logic                         cfg_wr_en,
  input  logic [rtc_pkg::CntW-1:0]     cfg_wr_data,
  input  logic                         in_cmd,
  input  logic [rtc_pkg::CntW-1:0]     in_cnt,
  output logic [rtc_pkg::YearW-1:0]    out_year,
  output logic [rtc_pkg::MonW-1:0]     out_month,
  output logic [rtc_pkg::DayW-1:0]     out_day,
  output logic [rtc_pkg::HourW-1:0]    out_hour,
  output logic [rtc_pkg::MinW-1:0]     out_minute,
  output logic [rtc_pkg::SecW-1:0]     out_second,
  output logic [rtc_pkg::CntW-1:0]     out_total
);
  import rtc_pkg::*;

  logic [CntW-1:0]  offset;
  logic [CntW-1:0]  last;
  logic             cmd_q;
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  rem;
  logic [YearW-1:0] year;
  logic [MonW-1:0]  month;
  logic [DayW-1:0]  day;
  logic [HourW-1:0] hour;
  logic [MinW-1:0]  minute;
  logic [SecW-1:0]  second;

  logic [CntW-1:0] jump;
  logic [CntW-1:0] cand;
  logic            leap;
  logic            take;
  logic            day_wrap;

  assign jump = cnt_q - last;
  assign leap = (year[1:0] == 2'b00);
  assign cand = step_cand(cmd.sel, cmd.shift, leap, month);
  // month scan stops at December whatever is left
  assign take = (rem >= cand) && !(cmd.sel == SEL_MON && month == LastMonth);
  assign day_wrap = ({1'b0, day} + 6'd1) >= {1'b0, month_days(leap, month)};

  assign stat.is_load = cmd_q;
  assign stat.same    = (cnt_q == last);
  assign stat.big     = (jump > MaxStepJump);
  assign stat.take    = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (cfg_wr_en) begin
      offset <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      cmd_q <= in_cmd;
      cnt_q <= in_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last   <= '0;
      year   <= '0;
      month  <= '0;
      day    <= '0;
      hour   <= '0;
      minute <= '0;
      second <= '0;
    end else begin
      case (cmd.op)
        OP_CONV_INIT: begin
          last   <= cnt_q;
          rem    <= offset + cnt_q;
          year   <= '0;
          month  <= '0;
          day    <= '0;
          hour   <= '0;
          minute <= '0;
        end
        OP_INC_INIT: begin
          last <= cnt_q;
          rem  <= CntW'(second) + jump;
        end
        OP_STEP: begin
          if (take) begin
            rem <= rem - cand;
          end
          case (cmd.sel)
            SEL_BLK:  year   <= {year[YearW-2:0], take};
            SEL_DAY:  day    <= {day[DayW-2:0], take};
            SEL_HOUR: hour   <= {hour[HourW-2:0], take};
            SEL_MIN:  minute <= {minute[MinW-2:0], take};
            // block count times four, plus one if past the leap year
            SEL_LEAP: year   <= {year[YearW-3:0], 2'b00} + YearW'(take);
            SEL_YEAR: year   <= year + YearW'(take);
            SEL_MON:  month  <= month + MonW'(take);
            SEL_INC: begin
              if (take) begin
                // one minute carry
                if (minute != LastMin) begin
                  minute <= minute + 6'd1;
                end else begin
                  minute <= '0;
                  if (hour != LastHour) begin
                    hour <= hour + 5'd1;
                  end else begin
                    hour <= '0;
                    if (!day_wrap) begin
                      day <= day + 5'd1;
                    end else begin
                      day <= '0;
                      if (month + 4'd1 < NumMonths) begin
                        month <= month + 4'd1;
                      end else begin
                        month <= '0;
                        year  <= year + 8'd1;
                      end
                    end
                  end
                end
              end else begin
                second <= rem[SecW-1:0];
              end
            end
            default: ;
          endcase
        end
        OP_SEC: second <= rem[SecW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_PUBLISH) begin
      out_year   <= year;
      out_month  <= month;
      out_day    <= day;
      out_hour   <= hour;
      out_minute <= minute;
      out_second <= second;
      out_total  <= offset + last;
    end
  end

endmodule

// ===== design/rtc_ctrl.sv =====
// Controller: sequences latch, conversion or increment steps, and output handoff.
module rtc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rtc_pkg::dp_cmd_t  cmd,
  input  rtc_pkg::dp_stat_t stat
);
  import rtc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_BLK    = 4'd2;
  localparam logic [3:0] S_LEAP   = 4'd3;
  localparam logic [3:0] S_YEAR   = 4'd4;
  localparam logic [3:0] S_MON    = 4'd5;
  localparam logic [3:0] S_DAY    = 4'd6;
  localparam logic [3:0] S_HOUR   = 4'd7;
  localparam logic [3:0] S_MIN    = 4'd8;
  localparam logic [3:0] S_SEC    = 4'd9;
  localparam logic [3:0] S_INC    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  localparam logic [ShiftW-1:0] BlkTop  = 3'd5;  // block count < 64
  localparam logic [ShiftW-1:0] DayTop  = 3'd4;  // day < 32
  localparam logic [ShiftW-1:0] HourTop = 3'd4;  // hour < 32
  localparam logic [ShiftW-1:0] MinTop  = 3'd5;  // minute < 64

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [ShiftW-1:0] shift;
  logic [ShiftW-1:0] shift_next;
  logic              publish;

  assign in_ready = (state == S_IDLE);
  assign publish  = (cmd.op == OP_PUBLISH);

  always_comb begin
    state_next = state;
    shift_next = shift;
    cmd.op     = OP_NONE;
    cmd.sel    = SEL_BLK;
    cmd.shift  = shift;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_load || (!stat.same && stat.big)) begin
          cmd.op     = OP_CONV_INIT;
          state_next = S_BLK;
          shift_next = BlkTop;
        end else if (stat.same) begin
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_INC_INIT;
          state_next = S_INC;
        end
      end
      S_BLK: begin
        cmd.op  = OP_STEP;
        cmd.sel = SEL_BLK;
        if (shift == '0) begin
          state_next = S_LEAP;
        end else begin
          shift_next = shift - 3'd1;
        end
      end
      S_LEAP: begin
        cmd.op     = OP_STEP;
        cmd.sel    = SEL_LEAP;
        state_next = stat.take ? S_YEAR : S_MON;
      end
      S_YEAR: begin
        cmd.op  = OP_STEP;
        cmd.sel = SEL_YEAR;
        if (!stat.take) begin
          state_next = S_MON;
        end
      end
      S_MON: begin
        cmd.op  = OP_STEP;
        cmd.sel = SEL_MON;
        if (!stat.take) begin
          state_next = S_DAY;
          shift_next = DayTop;
        end
      end
      S_DAY: begin
        cmd.op  = OP_STEP;
        cmd.sel = SEL_DAY;
        if (shift == '0) begin
          state_next = S_HOUR;
          shift_next = HourTop;
        end else begin
          shift_next = shift - 3'd1;
        end
      end
      S_HOUR: begin
        cmd.op  = OP_STEP;
        cmd.sel = SEL_HOUR;
        if (shift == '0) begin
          state_next = S_MIN;
          shift_next = MinTop;
        end else begin
          shift_next = shift - 3'd1;
        end
      end
      S_MIN: begin
        cmd.op  = OP_STEP;
        cmd.sel = SEL_MIN;
        if (shift == '0) begin
          state_next = S_SEC;
        end else begin
          shift_next = shift - 3'd1;
        end
      end
      S_SEC: begin
        cmd.op     = OP_SEC;
        state_next = S_DONE;
      end
      S_INC: begin
        cmd.op  = OP_STEP;
        cmd.sel = SEL_INC;
        if (!stat.take) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      shift     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      shift <= shift_next;
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/rtc_calendar_tracker.sv =====
// RTC calendar tracker top level: controller plus datapath behind two valid/ready channels.
//
// Keeps a calendar (years since 2012 modulo 256, month, day, hour, minute,
// second) from readings of a free-running seconds counter. A load command
// (cmd = 1) stores the reading and converts epoch_offset + reading in full:
// the remainder is split into 4-year blocks of 1461 days, then years, then
// months, then day, hour and minute, one restoring compare/subtract per clock
// in a single shared 32-bit subtract unit. A check command (cmd = 0) adds the
// jump since the previous reading (modulo 2^32) to the seconds, carrying one
// minute per clock; a jump above 180 s triggers a full conversion and an
// unchanged reading leaves the calendar as is. A year is leap when
// (year mod 4) == 0, also after the year wraps. Every input transaction gives
// exactly one output transaction showing the calendar after it, with
// total_seconds = epoch_offset + last reading. From acceptance to the result
// in the output register, an unchanged reading goes straight to the handoff;
// an incremental check runs one carry step per minute carry (at most three);
// a full conversion runs the digit steps (6 block, 5 day, 5 hour, 6 minute),
// up to 3 year steps and up to 12 month steps. One transaction is worked at
// a time; the input is ready again in the cycle after the result is handed to
// the output register, which holds it until taken. The user must write
// epoch_offset through cfg_wr_en/cfg_wr_data only while idle; the block does
// not enforce it. It takes effect at the next full conversion and the next total_seconds.
module rtc_calendar_tracker (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [rtc_pkg::CntW-1:0] cfg_wr_data,
  rtc_in_if.sink                   in_ch,
  rtc_out_if.source                out_ch
);
  import rtc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  rtc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (in_ch.cmd),
    .in_cnt      (in_ch.counter_value),
    .out_year    (out_ch.year),
    .out_month   (out_ch.month),
    .out_day     (out_ch.day),
    .out_hour    (out_ch.hour),
    .out_minute  (out_ch.minute),
    .out_second  (out_ch.second),
    .out_total   (out_ch.total_seconds)
  );

endmodule

// ===== tb/rtc_calendar_tracker_test.sv =====
// Self-checking testbench for the RTC calendar tracker: random stimulus, predictor, scoreboard.
`timescale 1ns / 100ps

module rtc_calendar_tracker_test;
  import rtc_pkg::*;

  // Calendar arithmetic constants for the predictor (32-bit, wrap like the hardware)
  localparam int unsigned HourSecs     = 3600;
  localparam int unsigned DaySecs      = 86400;
  localparam int unsigned YearSecs     = 365 * DaySecs;
  localparam int unsigned LeapYearSecs = 366 * DaySecs;
  localparam int unsigned QuadSecs     = 4 * YearSecs + DaySecs;   // leap year + 3 common
  localparam int unsigned MaxIncJump   = 180;                      // above this: full reconvert
  localparam int unsigned LastYearPick = 135;                      // keeps targets below 2^32

  // Command encoding on the input channel
  localparam logic CmdCheck = 1'b0;
  localparam logic CmdLoad  = 1'b1;

  // Run control
  localparam int IdleLimit   = 3000;   // cycles with no transaction before giving up
  localparam int HoldCycles  = 300;    // long receiver hold-off, fills the block up
  localparam int PhaseItems  = 190;    // random readings per offset setting
  localparam int NumPhases   = 6;
  localparam int SettleDelay = 4;      // idle cycles before an offset write
  localparam int DrainCycles = 60;     // longer than a worst-case full conversion

  typedef enum logic [1:0] {
    SendRareRecvOften,   // sender idles 9%, receiver idles 85%
    SendOftenRecvRare,   // sender idles 85%, receiver idles 9%
    NoIdle
  } idle_mode_t;

  typedef struct packed {
    logic            cmd;
    logic [CntW-1:0] count;
  } reading_t;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
    logic [CntW-1:0]  total;
  } calendar_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_wr_en;
  logic [CntW-1:0] cfg_wr_data;

  rtc_in_if  in_ch();
  rtc_out_if out_ch();

  rtc_calendar_tracker uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Readings waiting to be driven, and calendars the block still owes us
  reading_t   reading_queue[$];
  calendar_t  cal_due[$];
  idle_mode_t idle_mode;

  int items_queued;     // pushed by the stimulus process
  int items_accepted;   // counted at the input handshake
  int mismatches;
  int hold_reqs;        // bumped by stimulus, served by the ready process
  int holds_served;
  int hold_left;
  bit in_taken;         // input transaction at the last rising edge

  // Predictor state: own copy of offset, last reading and calendar
  logic [CntW-1:0] epoch_reg;
  logic [CntW-1:0] prev_count;
  calendar_t       cal_now;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned month_len(logic leap, int unsigned mon);
    int unsigned days;
    case (mon)
      1:             days = leap ? 29 : 28;
      3, 5, 8, 10:   days = 30;
      0, 2, 4, 6, 7,
      9, 11:         days = 31;
      default:       days = 30;   // month out of range never happens in practice
    endcase
    return days;
  endfunction

  // Full conversion of offset + last reading into the calendar.
  // Each 4-year block opens with the leap year; remainders equal to a whole
  // year roll into the next year (>= compares).
  function automatic void convert_all();
    int unsigned t, quads, yr, mon;
    logic        leap_tab;
    t        = epoch_reg + prev_count;
    quads    = t / QuadSecs;
    yr       = quads * 4;
    t        = t - quads * QuadSecs;
    leap_tab = 1'b1;
    if (t >= LeapYearSecs) begin
      t        = t - LeapYearSecs;
      yr       = yr + 1;
      leap_tab = 1'b0;
      while (t >= YearSecs) begin
        t  = t - YearSecs;
        yr = yr + 1;
      end
    end
    mon = 0;
    while (mon < 11 && t >= month_len(leap_tab, mon) * DaySecs) begin
      t   = t - month_len(leap_tab, mon) * DaySecs;
      mon = mon + 1;
    end
    cal_now.year   = YearW'(yr);
    cal_now.month  = MonW'(mon);
    cal_now.day    = DayW'(t / DaySecs);
    t              = t % DaySecs;
    cal_now.hour   = HourW'(t / HourSecs);
    t              = t % HourSecs;
    cal_now.minute = MinW'(t / 60);
    cal_now.second = SecW'(t % 60);
  endfunction

  // One minute carry, rippling up to the year (year wraps mod 256,
  // leap test is year mod 4)
  function automatic void carry_one_minute();
    if (cal_now.minute != 6'd59) begin
      cal_now.minute = cal_now.minute + 1'b1;
    end else begin
      cal_now.minute = '0;
      if (cal_now.hour != 5'd23) begin
        cal_now.hour = cal_now.hour + 1'b1;
      end else begin
        cal_now.hour = '0;
        if (cal_now.day + 1 < month_len(cal_now.year[1:0] == 2'b00, cal_now.month)) begin
          cal_now.day = cal_now.day + 1'b1;
        end else begin
          cal_now.day = '0;
          if (cal_now.month != 4'd11) begin
            cal_now.month = cal_now.month + 1'b1;
          end else begin
            cal_now.month = '0;
            cal_now.year  = cal_now.year + 1'b1;
          end
        end
      end
    end
  endfunction

  // Apply one reading to the predictor; returns the calendar the block must show
  function automatic calendar_t track_reading(reading_t rd);
    int unsigned jump, secs;
    if (rd.cmd == CmdLoad) begin
      prev_count = rd.count;
      convert_all();
    end else if (rd.count != prev_count) begin
      jump       = rd.count - prev_count;   // mod 2^32, covers counter wrap
      prev_count = rd.count;
      if (jump > MaxIncJump) begin
        convert_all();
      end else begin
        secs = cal_now.second + jump;
        while (secs >= 60) begin
          secs = secs - 60;
          carry_one_minute();
        end
        cal_now.second = SecW'(secs);
      end
    end
    cal_now.total = epoch_reg + prev_count;
    return cal_now;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_reading(logic cmd, logic [CntW-1:0] count);
    reading_t rd;
    rd.cmd   = cmd;
    rd.count = count;
    reading_queue.push_back(rd);
    items_queued++;
  endtask

  // Seconds since the epoch at the start of month m of year y
  function automatic int unsigned month_start(int unsigned y, int unsigned m);
    int unsigned days;
    days = y * 365 + (y + 3) / 4;
    for (int unsigned i = 0; i < m; i++)
      days = days + month_len(y % 4 == 0, i);
    return days * DaySecs;
  endfunction

  // One random sequence: mostly a load landing just short of a boundary
  // followed by small checks that carry across it; some plain noise.
  task automatic add_random_run();
    int unsigned     r, target;
    logic [CntW-1:0] cnt;
    logic            cmd;
    if ($urandom_range(0, 99) < 20) begin
      push_reading(1'($urandom_range(0, 1)), $urandom());
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          target = month_start($urandom_range(0, LastYearPick), $urandom_range(0, 11));
          cnt    = target - $urandom_range(1, 200) - epoch_reg;
        end
        1: begin
          target = $urandom_range(0, 49709) * DaySecs;
          cnt    = target - $urandom_range(1, 200) - epoch_reg;
        end
        2:       cnt = $urandom();
        default: cnt = 32'hFFFF_FFFF - $urandom_range(0, 300);   // counter about to wrap
      endcase
      push_reading(CmdLoad, cnt);
      repeat ($urandom_range(1, 10)) begin
        r   = $urandom_range(0, 99);
        cmd = CmdCheck;
        if (r < 8)       cnt = cnt;                           // unchanged reading
        else if (r < 14) cnt = cnt + MaxIncJump;
        else if (r < 18) cnt = cnt + MaxIncJump + 1;
        else if (r < 22) cnt = cnt + $urandom();              // big jump
        else if (r < 25) begin
          cmd = CmdLoad;
          cnt = cnt + $urandom_range(0, MaxIncJump);
        end else         cnt = cnt + $urandom_range(1, MaxIncJump - 1);
        push_reading(cmd, cnt);
      end
    end
  endtask

  // Offset write; only called with the block idle
  task automatic write_offset(logic [CntW-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    epoch_reg    = value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic wait_drained();
    while (items_accepted != items_queued || cal_due.size() != 0)
      @(negedge clk);
  endtask

  function automatic bit sender_skips();
    case (idle_mode)
      SendRareRecvOften: return $urandom_range(0, 99) < 9;
      SendOftenRecvRare: return $urandom_range(0, 99) < 85;
      default:           return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_skips();
    case (idle_mode)
      SendRareRecvOften: return $urandom_range(0, 99) < 85;
      SendOftenRecvRare: return $urandom_range(0, 99) < 9;
      default:           return 1'b0;
    endcase
  endfunction

  task automatic report_error(string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next reading at the falling edge; valid holds until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : feed
    reading_t rd;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (reading_queue.size() != 0 && !sender_skips()) begin
        rd = reading_queue.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.cmd           <= rd.cmd;
        in_ch.counter_value <= rd.count;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready: random stalls, plus the long hold-off on request
  always @(negedge clk) begin : drain_side
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_reqs != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left    <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !receiver_skips();
    end
  end

  // ---------------------------------------------------------------------------
  // Input monitor: every accepted reading gets its expected calendar queued
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : in_watch
    reading_t rd;
    in_taken = 1'b0;
    if (!rst && in_ch.valid && in_ch.ready) begin
      in_taken = 1'b1;
      rd.cmd   = in_ch.cmd;
      rd.count = in_ch.counter_value;
      cal_due.push_back(track_reading(rd));
      items_accepted++;
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: compare each result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : out_watch
    calendar_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.year   = out_ch.year;
      got.month  = out_ch.month;
      got.day    = out_ch.day;
      got.hour   = out_ch.hour;
      got.minute = out_ch.minute;
      got.second = out_ch.second;
      got.total  = out_ch.total_seconds;
      if (cal_due.size() == 0) begin
        report_error($sformatf("result with nothing pending, total_seconds %0d", got.total));
      end else begin
        want = cal_due.pop_front();
        if (got.year != want.year)
          report_error($sformatf("year got %0d want %0d", got.year, want.year));
        if (got.month != want.month)
          report_error($sformatf("month got %0d want %0d", got.month, want.month));
        if (got.day != want.day)
          report_error($sformatf("day got %0d want %0d", got.day, want.day));
        if (got.hour != want.hour)
          report_error($sformatf("hour got %0d want %0d", got.hour, want.hour));
        if (got.minute != want.minute)
          report_error($sformatf("minute got %0d want %0d", got.minute, want.minute));
        if (got.second != want.second)
          report_error($sformatf("second got %0d want %0d", got.second, want.second));
        if (got.total != want.total)
          report_error($sformatf("total_seconds got %0d want %0d", got.total, want.total));
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin : watchdog
    int quiet;
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int target;
    // known values on every block input from time zero
    rst                 = 1'b1;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CmdCheck;
    in_ch.counter_value = '0;
    out_ch.ready        = 1'b0;
    idle_mode           = SendRareRecvOften;
    epoch_reg           = '0;
    prev_count          = '0;
    cal_now             = '0;
    items_queued        = 0;
    items_accepted      = 0;
    mismatches          = 0;
    hold_reqs           = 0;
    holds_served        = 0;
    hold_left           = 0;
    in_taken            = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: offset still at its reset value of zero
    push_reading(CmdCheck, 32'd0);                         // unchanged right after reset
    push_reading(CmdCheck, 32'd1);
    push_reading(CmdCheck, 32'd181);                       // largest incremental jump
    push_reading(CmdCheck, 32'd362);                       // one past it: reconvert
    push_reading(CmdLoad,  32'd59);
    push_reading(CmdCheck, 32'd239);                       // 59 s + 180: three minute carries
    push_reading(CmdLoad,  32'hFFFF_FFFF);                 // largest reading
    push_reading(CmdCheck, 32'h0000_0010);                 // counter wraps on check
    push_reading(CmdLoad,  LeapYearSecs - 1);              // last second of first year
    push_reading(CmdCheck, LeapYearSecs);                  // carry into the next year
    push_reading(CmdLoad,  LeapYearSecs);                  // remainder exactly one year
    push_reading(CmdLoad,  LeapYearSecs + YearSecs);       // exactly two years
    push_reading(CmdLoad,  59 * DaySecs - 1);              // end of Feb 28, leap year
    push_reading(CmdCheck, 59 * DaySecs);                  // -> Feb 29
    push_reading(CmdLoad,  60 * DaySecs - 1);              // end of Feb 29
    push_reading(CmdCheck, 60 * DaySecs + 179);            // -> Mar 1
    push_reading(CmdLoad,  LeapYearSecs + 59 * DaySecs - 1); // end of Feb 28, common year
    push_reading(CmdCheck, LeapYearSecs + 59 * DaySecs);   // -> Mar 1
    push_reading(CmdLoad,  QuadSecs - 1);                  // end of a 4-year block
    push_reading(CmdCheck, QuadSecs + 179);                // carry into the next block
    push_reading(CmdLoad,  QuadSecs);
    push_reading(CmdCheck, 32'hFFFF_FFFF);                 // huge jump on check
    push_reading(CmdLoad,  32'd0);
    push_reading(CmdCheck, 32'd0);                         // unchanged after a load
    wait_drained();

    // Random phases, each under its own offset and idle pattern. Every phase
    // opens with a long receiver hold-off while the sender keeps offering, and
    // closes with the sender paused until every result is back.
    for (int p = 0; p < NumPhases; p++) begin
      case (p / 2)
        0:       idle_mode = SendRareRecvOften;
        1:       idle_mode = SendOftenRecvRare;
        default: idle_mode = NoIdle;
      endcase
      repeat (SettleDelay) @(negedge clk);
      case (p)
        0:       write_offset(32'hFFFF_FFFF);
        2:       write_offset(32'd0);
        5:       write_offset(32'h8000_0000);
        default: write_offset($urandom());
      endcase
      target = items_queued + PhaseItems;
      while (items_queued < target)
        add_random_run();
      hold_reqs++;
      wait_drained();
    end

    // let anything stray show up before the verdict
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && cal_due.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
